### src/toroidal_diffusion_decay_step_assert.svh
// Assertion macros for the diffusion grid block.
`ifndef TOROIDAL_DIFFUSION_DECAY_STEP_ASSERT_SVH
`define TOROIDAL_DIFFUSION_DECAY_STEP_ASSERT_SVH
`ifndef SYNTHESIS
`define TDD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define TDD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define TDD_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define TDD_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

### src/tdd_pkg.sv
`timescale 1ns / 1ps
package tdd_pkg;
    localparam int MAX_COLS_DEF = 64;
    localparam int MAX_ROWS_DEF = 64;

    typedef enum logic [1:0] {
        FUNC_WRITE = 2'd0,
        FUNC_STEP  = 2'd1,
        FUNC_READ  = 2'd2,
        FUNC_NOP   = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        REG_WIDTH  = 2'd0,
        REG_HEIGHT = 2'd1,
        REG_DIFF   = 2'd2,
        REG_DECAY  = 2'd3
    } t_reg;

    typedef struct packed {
        logic [1:0]  func;
        logic [5:0]  col;
        logic [5:0]  row;
        logic [31:0] amount_in;
    } t_in;

    typedef struct packed {
        logic [31:0] amount_out;
        logic        status;
    } t_out;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RD,
        ST_RESP,
        ST_OWAIT,
        ST_S_ADDR,
        ST_S_ACC,
        ST_S_CALC,
        ST_S_MUL,
        ST_S_WR,
        ST_C_ADDR,
        ST_C_WR
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic clr_start;   // reset cell counters
        logic clr_wr;      // write zero at clear counter
        logic acc_clear;
        logic acc_add;     // add amount read data, advance tap
        logic tap_reset;
        logic calc;        // register t and factor
        logic mul;         // register product
        logic next_wr;     // write next store
        logic copy_wr;     // write amount store from next store
        logic cell_inc;    // advance sweep cell
        logic req_rd;      // read for request
        logic req_wr;      // write for request
        logic load_out;    // capture result
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic clr_last;
        logic tap_last;
        logic cell_last;
    } t_sts;
endpackage

### src/tdd_ram.sv
`timescale 1ns / 1ps
module tdd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

### src/tdd_ctrl.sv
`timescale 1ns / 1ps
module tdd_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  tdd_pkg::t_in  i_in,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    input  tdd_pkg::t_sts i_sts,
    output tdd_pkg::t_cmd o_cmd,
    output logic          o_idle
);
    import tdd_pkg::*;
`include "toroidal_diffusion_decay_step_assert.svh"

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   in_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_idle      = (r_state == ST_IDLE);
    // new request taken while a result waits; its result waits in ST_RESP until the slot frees
    assign o_in_ready  = (r_state == ST_IDLE);
    assign in_acc      = i_in_valid && o_in_ready;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            ST_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_acc) begin
                    if (t_func'(i_in.func) == FUNC_STEP) begin
                        o_cmd.clr_start = 1'b1;
                        n_state         = ST_S_ADDR;
                    end else begin
                        o_cmd.req_rd = 1'b1;
                        o_cmd.req_wr = 1'b1;
                        n_state      = ST_RD;
                    end
                end
            end
            ST_RD: begin
                n_state = ST_RESP;
            end
            ST_RESP: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            ST_S_ADDR: begin
                o_cmd.tap_reset = 1'b1;
                o_cmd.acc_clear = 1'b1;
                n_state         = ST_S_ACC;
            end
            ST_S_ACC: begin
                o_cmd.acc_add = 1'b1;
                if (i_sts.tap_last) begin
                    n_state = ST_S_CALC;
                end
            end
            ST_S_CALC: begin
                o_cmd.calc = 1'b1;
                n_state    = ST_S_MUL;
            end
            ST_S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = ST_S_WR;
            end
            ST_S_WR: begin
                o_cmd.next_wr  = 1'b1;
                o_cmd.cell_inc = 1'b1;
                if (i_sts.cell_last) begin
                    o_cmd.clr_start = 1'b1;
                    n_state         = ST_C_ADDR;
                end else begin
                    n_state = ST_S_ADDR;
                end
            end
            ST_C_ADDR: begin
                n_state = ST_C_WR;
            end
            ST_C_WR: begin
                o_cmd.copy_wr  = 1'b1;
                o_cmd.cell_inc = 1'b1;
                if (i_sts.cell_last) begin
                    n_state = ST_RESP;
                end else begin
                    n_state = ST_C_ADDR;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    `TDD_ASSERT_IMP(a_ready_idle, i_clk, i_rst_n, o_in_ready, r_state == ST_IDLE)
    `TDD_ASSERT_NXT(a_load_sets_valid, i_clk, i_rst_n, o_cmd.load_out, r_out_valid)
    `TDD_ASSERT_IMP(a_no_overwrite, i_clk, i_rst_n, o_cmd.load_out, !r_out_valid || i_out_ready)
    `TDD_ASSERT_IMP(a_wr_excl, i_clk, i_rst_n, o_cmd.next_wr, !o_cmd.copy_wr)
endmodule

### src/tdd_dp.sv
`timescale 1ns / 1ps
module tdd_dp #(
    parameter int MAX_COLS = tdd_pkg::MAX_COLS_DEF,
    parameter int MAX_ROWS = tdd_pkg::MAX_ROWS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  tdd_pkg::t_in  i_in,
    input  logic [6:0]    i_w,
    input  logic [6:0]    i_h,
    input  logic [15:0]   i_p,
    input  logic [15:0]   i_d,
    input  tdd_pkg::t_cmd i_cmd,
    output tdd_pkg::t_sts o_sts,
    output tdd_pkg::t_out o_out
);
    import tdd_pkg::*;

    localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int DEPTH = MAX_COLS * MAX_ROWS;
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [8:0] MAXC = 9'(MAX_COLS);
    localparam logic [8:0] MAXR = 9'(MAX_ROWS);

    // clamped size in use
    logic [8:0] w9, h9;
    always_comb begin
        w9 = {2'b0, i_w};
        h9 = {2'b0, i_h};
        if (w9 == 9'd0) w9 = 9'd1;
        if (w9 > MAXC) w9 = MAXC;
        if (h9 == 9'd0) h9 = 9'd1;
        if (h9 > MAXR) h9 = MAXR;
    end

    logic [CW-1:0] r_x;
    logic [RW-1:0] r_y;
    logic [3:0]    r_tap;
    logic [35:0]   r_acc;
    logic [31:0]   r_a;
    logic signed [51:0] r_t;
    logic [16:0]   r_m;
    logic [31:0]   r_res;
    logic [AW-1:0] r_clr;
    t_in           r_req;
    logic          r_bad;
    logic          r_rd_v;    // request read data arrives this cycle
    logic [31:0]   r_rdat;    // request read data, held until the result is loaded

    logic          am_we, nx_we;
    logic [AW-1:0] am_wa, am_ra, nx_wa;
    logic [31:0]   am_wd, am_rd, nx_rd;

    logic [AW-1:0] cell_addr;
    assign cell_addr = AW'(r_y) * AW'(MAX_COLS) + AW'(r_x);

    // first tap of a cell is always tap 0
    logic [3:0] tap_sel;
    assign tap_sel = i_cmd.tap_reset ? 4'd0 : r_tap;

    // tap neighbour address, tap 0..8 = row offset tap/3-1, col offset tap%3-1
    logic [1:0] dy, dx;
    logic [8:0] xx, yy;
    always_comb begin
        case (tap_sel)
            4'd0: begin dy = 2'd0; dx = 2'd0; end
            4'd1: begin dy = 2'd0; dx = 2'd1; end
            4'd2: begin dy = 2'd0; dx = 2'd2; end
            4'd3: begin dy = 2'd1; dx = 2'd0; end
            4'd4: begin dy = 2'd1; dx = 2'd1; end
            4'd5: begin dy = 2'd1; dx = 2'd2; end
            4'd6: begin dy = 2'd2; dx = 2'd0; end
            4'd7: begin dy = 2'd2; dx = 2'd1; end
            default: begin dy = 2'd2; dx = 2'd2; end
        endcase
        xx = 9'(r_x) + 9'(dx) + w9 - 9'd1;
        if (xx >= w9) xx = xx - w9;
        if (xx >= w9) xx = xx - w9;
        yy = 9'(r_y) + 9'(dy) + h9 - 9'd1;
        if (yy >= h9) yy = yy - h9;
        if (yy >= h9) yy = yy - h9;
    end

    logic [AW-1:0] tap_addr, req_addr;
    assign tap_addr = AW'(yy) * AW'(MAX_COLS) + AW'(xx);
    assign req_addr = AW'(i_in.row) * AW'(MAX_COLS) + AW'(i_in.col);

    logic in_bad;
    assign in_bad = ({3'b0, i_in.col} >= w9) || ({3'b0, i_in.row} >= h9);

    // tap read issued the cycle before its add; r_tap counts reads, data is for tap r_tap-1
    always_comb begin
        am_ra = cell_addr;
        if (i_cmd.req_rd) am_ra = req_addr;
        else if (i_cmd.acc_add || i_cmd.tap_reset) am_ra = tap_addr;
        am_we = 1'b0;
        am_wa = cell_addr;
        am_wd = nx_rd;
        if (i_cmd.clr_wr) begin
            am_we = 1'b1; am_wa = r_clr; am_wd = '0;
        end else if (i_cmd.req_wr && t_func'(i_in.func) == FUNC_WRITE && !in_bad) begin
            am_we = 1'b1; am_wa = req_addr; am_wd = i_in.amount_in;
        end else if (i_cmd.copy_wr) begin
            am_we = 1'b1;
        end
        nx_we = i_cmd.next_wr;
        nx_wa = cell_addr;
    end

    tdd_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_amount (
        .i_clk(i_clk), .i_we(am_we), .i_waddr(am_wa), .i_wdata(am_wd),
        .i_raddr(am_ra), .o_rdata(am_rd)
    );
    tdd_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_next (
        .i_clk(i_clk), .i_we(nx_we), .i_waddr(nx_wa), .i_wdata(r_res),
        .i_raddr(cell_addr), .o_rdata(nx_rd)
    );

    // arithmetic
    logic signed [36:0] diff;
    logic signed [52:0] t_full;
    logic [35:0]  ut;
    logic [52:0]  prod_hi, prod_lo;
    assign diff = $signed({1'b0, r_acc}) - $signed(37'(r_a) * 37'd9);
    assign t_full = $signed({5'b0, r_a, 16'b0})
                  + $signed({1'b0, i_p}) * diff;
    assign ut = r_t[51:16];
    assign prod_hi = 53'(ut) * 53'(r_m);
    assign prod_lo = 53'((53'(r_t[15:0]) * 53'(r_m)) >> 16);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr  <= '0;
            r_tap  <= '0;
            r_x    <= '0;
            r_y    <= '0;
            r_rd_v <= 1'b0;
        end else begin
            r_rd_v <= i_cmd.req_rd;
            if (i_cmd.clr_wr) r_clr <= r_clr + AW'(1);
            if (i_cmd.clr_start) begin
                r_x <= '0;
                r_y <= '0;
            end else if (i_cmd.cell_inc) begin
                if (9'(r_x) + 9'd1 >= w9) begin
                    r_x <= '0;
                    r_y <= (9'(r_y) + 9'd1 >= h9) ? '0 : r_y + RW'(1);
                end else begin
                    r_x <= r_x + CW'(1);
                end
            end
            if (i_cmd.tap_reset) begin
                r_tap <= 4'd1;
            end else if (i_cmd.acc_add) begin
                r_tap <= r_tap + 4'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.acc_clear) r_acc <= '0;
        else if (i_cmd.acc_add) r_acc <= r_acc + 36'(am_rd);
        if (i_cmd.acc_add && r_tap == 4'd5) r_a <= am_rd; // tap 4 is self
        if (i_cmd.calc) begin
            r_t <= (t_full < 0) ? '0 : t_full[51:0];
            r_m <= 17'd65536 - 17'(i_d);
        end
        if (i_cmd.mul) begin
            r_res <= ((prod_hi + prod_lo) >> 16) > 53'hFFFF_FFFF ? 32'hFFFF_FFFF
                   : 32'((prod_hi + prod_lo) >> 16);
        end
        if (i_cmd.req_rd) begin
            r_req <= i_in;
            r_bad <= in_bad;
        end
        if (r_rd_v) r_rdat <= am_rd;
        if (i_cmd.load_out) begin
            o_out.amount_out <= (t_func'(r_req.func) == FUNC_READ && !r_bad) ? r_rdat : '0;
            o_out.status <= (t_func'(r_req.func) == FUNC_READ
                          || t_func'(r_req.func) == FUNC_WRITE) && r_bad;
        end
        if (i_cmd.clr_start) r_req.func <= FUNC_STEP;
    end

    assign o_sts.clr_last  = (r_clr == AW'(DEPTH - 1));
    assign o_sts.tap_last  = (r_tap == 4'd9);
    assign o_sts.cell_last = (9'(r_x) + 9'd1 >= w9) && (9'(r_y) + 9'd1 >= h9);
endmodule

### src/toroidal_diffusion_decay_step.sv
`timescale 1ns / 1ps
// Toroidal 3x3 diffusion/decay grid. Each request returns one result. A step
// request sweeps the grid in use twice: first each cell gathers its 9 wrapped
// neighbours through the single read port of the amount RAM and runs the
// fixed-point update into the next store, then the new values are copied
// back. After reset a clearing pass zeroes the grid, one cell per cycle, before
// the first request is taken. Config writes are taken only while the block is
// idle between requests.
module toroidal_diffusion_decay_step #(
    parameter int MAX_COLS = tdd_pkg::MAX_COLS_DEF,
    parameter int MAX_ROWS = tdd_pkg::MAX_ROWS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  tdd_pkg::t_in  i_in,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output tdd_pkg::t_out o_out,
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic [1:0]    i_cfg_index,
    input  logic [15:0]   i_cfg_data
);
    import tdd_pkg::*;

    // configuration registers
    logic [6:0]  r_w, r_h;
    logic [15:0] r_p, r_d;
    t_cmd cmd;
    t_sts sts;
    logic idle;

    // sizes and fractions must not move under a sweep or clearing pass
    assign o_cfg_ready = idle;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w <= 7'd64;
            r_h <= 7'd64;
            r_p <= '0;
            r_d <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_reg'(i_cfg_index))
                REG_WIDTH:  r_w <= i_cfg_data[6:0];
                REG_HEIGHT: r_h <= i_cfg_data[6:0];
                REG_DIFF:   r_p <= i_cfg_data;
                REG_DECAY:  r_d <= i_cfg_data;
                default:    r_p <= r_p;
            endcase
        end
    end

    tdd_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in(i_in),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .i_sts(sts), .o_cmd(cmd), .o_idle(idle)
    );

    tdd_dp #(.MAX_COLS(MAX_COLS), .MAX_ROWS(MAX_ROWS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(i_in),
        .i_w(r_w), .i_h(r_h), .i_p(r_p), .i_d(r_d),
        .i_cmd(cmd), .o_sts(sts), .o_out(o_out)
    );
endmodule

### verif/tdd_grid_checker.sv
`timescale 1ns / 1ps
// Watches the request, config and result channels, keeps a copy of the grid
// and compares every result with the oldest prediction.
module tdd_grid_checker (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_in_ready,
    input  tdd_pkg::t_in  i_in,
    input  logic          i_out_valid,
    input  logic          i_out_ready,
    input  tdd_pkg::t_out i_out,
    input  logic          i_cfg_valid,
    input  logic          i_cfg_ready,
    input  logic [1:0]    i_cfg_index,
    input  logic [15:0]   i_cfg_data,
    output int            o_fail_count,
    output int            o_pending
);
    import tdd_pkg::*;

    localparam int NCOL = MAX_COLS_DEF;
    localparam int NROW = MAX_ROWS_DEF;
    localparam int QDEPTH = 64;

    logic [6:0]    width_reg;
    logic [6:0]    height_reg;
    logic [15:0]   diff_frac;
    logic [15:0]   decay_frac;
    logic [31:0]   cell_amt [NCOL*NROW];
    logic [31:0]   cell_nxt [NCOL*NROW];
    t_out          result_ring [QDEPTH];
    int            ring_wr;
    int            ring_rd;
    int            mismatches;

    assign o_fail_count = mismatches;
    assign o_pending    = ring_wr - ring_rd;

    function automatic int clamp_dim(logic [6:0] v, int maxv);
        if (v == 0) return 1;
        if (int'(v) > maxv) return maxv;
        return int'(v);
    endfunction

    // Q16.16 update: t = a*2^16 + p*(S-9a), floored at zero, then scale by (1-d), saturate.
    function automatic logic [31:0] diffuse_cell(logic [31:0] a, longint s);
        longint t;
        longint hi;
        longint lo;
        longint m;
        longint r;
        t = longint'(a) * 65536 + longint'(diff_frac) * (s - 9 * longint'(a));
        if (t < 0) return 32'd0;
        m  = 65536 - longint'(decay_frac);
        hi = t >>> 16;
        lo = t & 64'hFFFF;
        r  = (hi * m + ((lo * m) >>> 16)) >>> 16;
        if (r > 64'hFFFF_FFFF) return 32'hFFFF_FFFF;
        return r[31:0];
    endfunction

    function void sweep_grid();
        int w;
        int h;
        int yn [3];
        int xn [3];
        longint s;
        w = clamp_dim(width_reg, NCOL);
        h = clamp_dim(height_reg, NROW);
        for (int y = 0; y < h; y++) begin
            yn[0] = (y == 0) ? h - 1 : y - 1;
            yn[1] = y;
            yn[2] = (y + 1 == h) ? 0 : y + 1;
            for (int x = 0; x < w; x++) begin
                xn[0] = (x == 0) ? w - 1 : x - 1;
                xn[1] = x;
                xn[2] = (x + 1 == w) ? 0 : x + 1;
                s = 0;
                for (int j = 0; j < 3; j++)
                    for (int i = 0; i < 3; i++)
                        s += longint'(cell_amt[yn[j]*NCOL + xn[i]]);
                cell_nxt[y*NCOL + x] = diffuse_cell(cell_amt[y*NCOL + x], s);
            end
        end
        for (int y = 0; y < h; y++)
            for (int x = 0; x < w; x++)
                cell_amt[y*NCOL + x] = cell_nxt[y*NCOL + x];
    endfunction

    function t_out predict_request(t_in rq);
        t_out res;
        int   w;
        int   h;
        res = '0;
        w = clamp_dim(width_reg, NCOL);
        h = clamp_dim(height_reg, NROW);
        case (t_func'(rq.func))
            FUNC_STEP: sweep_grid();
            FUNC_WRITE, FUNC_READ: begin
                if (int'(rq.col) >= w || int'(rq.row) >= h)
                    res.status = 1'b1;
                else if (t_func'(rq.func) == FUNC_WRITE)
                    cell_amt[rq.row*NCOL + rq.col] = rq.amount_in;
                else
                    res.amount_out = cell_amt[rq.row*NCOL + rq.col];
            end
            default: ;
        endcase
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_out want;
        if (!i_rst_n) begin
            width_reg  = 7'd64;
            height_reg = 7'd64;
            diff_frac  = '0;
            decay_frac = '0;
            for (int k = 0; k < NCOL*NROW; k++) cell_amt[k] = '0;
            ring_wr    = 0;
            ring_rd    = 0;
            mismatches = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (t_reg'(i_cfg_index))
                    REG_WIDTH:  width_reg  = i_cfg_data[6:0];
                    REG_HEIGHT: height_reg = i_cfg_data[6:0];
                    REG_DIFF:   diff_frac  = i_cfg_data;
                    REG_DECAY:  decay_frac = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                result_ring[ring_wr % QDEPTH] = predict_request(i_in);
                ring_wr++;
            end
            if (i_out_valid && i_out_ready) begin
                if (ring_wr == ring_rd) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("chk: unexpected result amount=%h status=%0d",
                                 i_out.amount_out, i_out.status);
                end else begin
                    want = result_ring[ring_rd % QDEPTH];
                    ring_rd++;
                    if (want.amount_out !== i_out.amount_out
                            || want.status !== i_out.status) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"chk: mismatch exp amount=%h status=%0d,",
                                      " got amount=%h status=%0d"},
                                     want.amount_out, want.status,
                                     i_out.amount_out, i_out.status);
                    end
                end
            end
        end
    end
endmodule

### verif/toroidal_diffusion_decay_step_tb.sv
`timescale 1ns / 1ps
module toroidal_diffusion_decay_step_tb;
    import tdd_pkg::*;

    // Only one step runs at the full 64x64 size.
    localparam int CYCLE_LIMIT = 4_000_000;

    logic  clk;
    logic  rst_n;
    logic  in_valid;
    logic  in_ready;
    t_in   in_req;
    logic  out_valid;
    logic  out_ready;
    t_out  out_res;
    logic  cfg_valid;
    logic  cfg_ready;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;
    int    fail_count;
    int    pending;
    int    cycles;
    int    snd_idle;   // percent of slots the request side holds off
    int    rcv_idle;   // percent of cycles the result side stalls
    int    cur_w;
    int    cur_h;

    toroidal_diffusion_decay_step i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_req),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_res),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    tdd_grid_checker i_chk (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in         (in_req),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out        (out_res),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Watchdog: a hung block ends the run here.
    initial cycles = 0;
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Result side: one ready decision per falling edge.
    always @(negedge clk) begin
        out_ready <= ($urandom_range(99) >= rcv_idle);
    end

    // Send one request. Valid is only dropped when a gap is drawn, so a
    // back-to-back request keeps valid high with a single assignment.
    task automatic send_request(t_func f, logic [5:0] c, logic [5:0] r, logic [31:0] amt);
        t_in rq;
        rq.func      = f;
        rq.col       = c;
        rq.row       = r;
        rq.amount_in = amt;
        @(negedge clk);
        while ($urandom_range(99) < snd_idle) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_req   <= rq;
        in_valid <= 1'b1;
        do @(posedge clk); while (!(in_valid && in_ready));
    endtask

    // Drain results, let the block settle, then write one register.
    task automatic write_reg(t_reg idx, logic [15:0] val);
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        @(negedge clk);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!(cfg_valid && cfg_ready));
        @(negedge clk);
        cfg_valid <= 1'b0;
        if (idx == REG_WIDTH)
            cur_w = (val[6:0] == 0) ? 1 : (val[6:0] > 64) ? 64 : int'(val[6:0]);
        if (idx == REG_HEIGHT)
            cur_h = (val[6:0] == 0) ? 1 : (val[6:0] > 64) ? 64 : int'(val[6:0]);
    endtask

    // Mostly addresses inside the grid in use, some anywhere in 0..63.
    function automatic logic [5:0] pick_coord(int lim);
        if ($urandom_range(9) == 0) return 6'($urandom_range(63));
        return 6'($urandom_range(lim - 1));
    endfunction

    function automatic logic [31:0] pick_amount();
        case ($urandom_range(5))
            0: return 32'hFFFF_FFFF;
            1: return 32'd0;
            2: return 32'($urandom_range(32'h0004_0000));
            default: return $urandom;
        endcase
    endfunction

    task automatic random_phase(int n_req);
        int    k;
        t_func f;
        // Small grids keep steps short; the size fields still get random high bits.
        write_reg(REG_WIDTH,  {9'($urandom_range(511)), 7'($urandom_range(1, 8))});
        write_reg(REG_HEIGHT, {9'($urandom_range(511)), 7'($urandom_range(1, 8))});
        write_reg(REG_DIFF,   ($urandom_range(3) == 0) ? 16'hFFFF : 16'($urandom_range(4096)));
        write_reg(REG_DECAY,  ($urandom_range(3) == 0) ? 16'd0 : 16'($urandom));
        for (k = 0; k < n_req; k++) begin
            case ($urandom_range(19))
                0, 1, 2, 3, 4, 5, 6, 7: f = FUNC_WRITE;
                8, 9, 10:               f = FUNC_STEP;
                19:                     f = FUNC_NOP;
                default:                f = FUNC_READ;
            endcase
            send_request(f, pick_coord(cur_w), pick_coord(cur_h), pick_amount());
        end
    endtask

    initial begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_req    = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_WIDTH;
        cfg_data  = '0;
        cur_w     = 64;
        cur_h     = 64;
        snd_idle  = 20;
        rcv_idle  = 52;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: corners of the full grid at reset sizes.
        send_request(FUNC_WRITE, 6'd63, 6'd63, 32'hFFFF_FFFF);
        send_request(FUNC_WRITE, 6'd0,  6'd0,  32'h0000_0001);
        send_request(FUNC_READ,  6'd63, 6'd63, 32'h0);
        send_request(FUNC_READ,  6'd0,  6'd0,  32'hFFFF_FFFF);
        send_request(FUNC_READ,  6'd17, 6'd42, 32'h0);
        send_request(FUNC_NOP,   6'd63, 6'd0,  32'hFFFF_FFFF);

        // 3x2 torus, all max but one empty cell, full diffusion: both saturations.
        write_reg(REG_WIDTH,  16'd3);
        write_reg(REG_HEIGHT, 16'd2);
        write_reg(REG_DIFF,   16'hFFFF);
        write_reg(REG_DECAY,  16'd0);
        for (int y = 0; y < 2; y++)
            for (int x = 0; x < 3; x++)
                send_request(FUNC_WRITE, 6'(x), 6'(y), (x == 1 && y == 1) ? 32'd0 : 32'hFFFF_FFFF);
        send_request(FUNC_STEP,  6'd0, 6'd0, 32'h0);
        send_request(FUNC_READ,  6'd1, 6'd1, 32'h0);
        send_request(FUNC_READ,  6'd0, 6'd0, 32'h0);
        // Outside the grid in use: no store, status set.
        send_request(FUNC_WRITE, 6'd3, 6'd0, 32'h1234_5678);
        send_request(FUNC_READ,  6'd0, 6'd2, 32'h0);
        send_request(FUNC_READ,  6'd63, 6'd63, 32'h0);

        // Zero size clamps to a single cell; heavy decay.
        write_reg(REG_WIDTH,  16'd0);
        write_reg(REG_HEIGHT, 16'd1);
        write_reg(REG_DECAY,  16'hFFFF);
        send_request(FUNC_STEP, 6'd0, 6'd0, 32'h0);
        send_request(FUNC_READ, 6'd0, 6'd0, 32'h0);

        // Oversize clamps to the full grid: one full-size sweep.
        write_reg(REG_WIDTH,  16'd127);
        write_reg(REG_HEIGHT, 16'd65);
        write_reg(REG_DIFF,   16'h1000);
        write_reg(REG_DECAY,  16'h0800);
        send_request(FUNC_STEP, 6'd0, 6'd0, 32'h0);
        send_request(FUNC_READ, 6'd63, 6'd63, 32'h0);
        send_request(FUNC_READ, 6'd0,  6'd63, 32'h0);

        random_phase(40);
        snd_idle = 52;
        rcv_idle = 20;
        random_phase(40);
        snd_idle = 0;
        rcv_idle = 0;
        random_phase(40);

        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (50) @(posedge clk);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule

### filelist.f
+incdir+src
src/tdd_pkg.sv
src/tdd_ram.sv
src/tdd_ctrl.sv
src/tdd_dp.sv
src/toroidal_diffusion_decay_step.sv
verif/tdd_grid_checker.sv
verif/toroidal_diffusion_decay_step_tb.sv
